/* rtl/core/dqne_pkg.sv */
// ----------------------------------------------------------------------------
// dqne_pkg
// Types and constants shared by the DNS question-name extractor modules.
// ----------------------------------------------------------------------------
package dqne_pkg;

	localparam int unsigned HEADER_BYTES = 12;
	localparam logic [7:0]  PTR_MASK     = 8'hC0;
	localparam logic [7:0]  OFFSET_MASK  = 8'h3F;
	localparam logic [7:0]  MAX_LABEL    = 8'd63;
	localparam logic [7:0]  DOT_CHAR     = 8'h2E;
	localparam int unsigned MAX_RESULTS  = 16;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} msg_t;

	typedef struct packed {
		logic [63:0] name_chunk;
		logic [3:0]  chunk_bytes;
		logic [6:0]  name_length;
		logic [1:0]  status;
		logic        last_chunk;
	} name_t;

	// controller -> datapath
	typedef struct packed {
		logic load_wr;     // store accepted byte
		logic walk_init;   // clear walk counters, point at question
		logic step_inc;    // count one walk step
		logic rd_cur;      // read packet byte at read pointer
		logic rd_next;     // read packet byte after read pointer
		logic rp_inc;      // advance past length byte
		logic label_go;    // start label copy (dot if name not empty)
		logic take_ptr;    // jump to compression target
		logic copy_rd;     // read next label byte
		logic copy_wr;     // write label byte to name store
		logic fin_done;    // status ok or empty
		logic fin_short;   // status short packet
		logic fin_bad;     // status bad label
		logic emit_rd;     // read name row for current chunk
		logic out_load;    // load output register
		logic chunk_inc;   // next chunk
		logic msg_clear;   // message done, clear length
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic eom;
		logic short_msg;
		logic loop_done;
		logic rp_end;
		logic is_ptr;
		logic ptr_next_end;
		logic ptr_bad;
		logic b_zero;
		logic label_bad;
		logic copy_more;
		logic out_done;
		logic out_last;
	} sts_t;

endpackage

/* rtl/core/dqne_datapath.sv */
// ----------------------------------------------------------------------------
// dqne_datapath
// Packet and name stores, walk pointers and counters, output register.
// ----------------------------------------------------------------------------
module dqne_datapath #(
	parameter int unsigned BUFFER_BYTES = 512,
	parameter int unsigned NAME_BYTES   = 128,
	parameter int unsigned MAX_STEPS    = 32,
	parameter int unsigned MAX_JUMPS    = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dqne_pkg::msg_t  msg_data,
	input  logic            name_stall,
	output logic            name_valid,
	output dqne_pkg::name_t name_data,
	input  dqne_pkg::cmd_t  cmd,
	output dqne_pkg::sts_t  sts
);

	localparam int LW   = $clog2(BUFFER_BYTES + 1);
	localparam int AW   = $clog2(BUFFER_BYTES);
	localparam int PW   = $clog2(NAME_BYTES);
	localparam int RW   = PW - 3;
	localparam int ROWS = (NAME_BYTES + 7) / 8;
	localparam int SW   = $clog2(MAX_STEPS + 1);
	localparam int JW   = $clog2(MAX_JUMPS + 1);
	localparam int XW   = LW + 7;

	localparam logic [PW-1:0] NAME_LIMIT = PW'(NAME_BYTES - 1);

	logic [7:0]    pkt_mem [BUFFER_BYTES];
	logic [63:0]   name_mem [ROWS];

	logic [LW-1:0] len_q;
	logic [LW-1:0] rp_q;
	logic [SW-1:0] steps_q;
	logic [JW-1:0] jumps_q;
	logic [PW-1:0] np_q;
	logic [5:0]    rem_q;
	logic [7:0]    b_q;
	logic [3:0]    chunk_q;
	logic [1:0]    status_q;
	logic [7:0]    pkt_rd_q;
	logic [63:0]   name_rd_q;
	logic          out_valid_q;
	dqne_pkg::name_t out_q;

	logic [LW:0]   rp1;
	logic [XW-1:0] label_end;
	logic          pkt_rd_en;
	logic [AW-1:0] pkt_rd_addr;
	logic          name_wr_en;
	logic [7:0]    name_wr_data;
	logic [8:0]    tot9;
	logic [8:0]    left9;
	logic [3:0]    nbytes;
	logic [5:0]    nchunks_raw;
	logic [4:0]    nchunks;
	logic [63:0]   chunk_word;

	assign rp1       = {1'b0, rp_q} + (LW+1)'(1);
	assign label_end = XW'(rp1) + XW'(pkt_rd_q);

	logic [13:0] jump_target;
	assign jump_target = {b_q[5:0] & dqne_pkg::OFFSET_MASK[5:0], pkt_rd_q};

	// status to controller
	always_comb begin
		sts.eom          = msg_data.end_of_message;
		sts.short_msg    = len_q < LW'(dqne_pkg::HEADER_BYTES);
		sts.loop_done    = (steps_q >= SW'(MAX_STEPS)) || (np_q >= NAME_LIMIT) ||
		                   (jumps_q >= JW'(MAX_JUMPS));
		sts.rp_end       = rp_q >= len_q;
		sts.is_ptr       = (pkt_rd_q & dqne_pkg::PTR_MASK) == dqne_pkg::PTR_MASK;
		sts.ptr_next_end = rp1 >= {1'b0, len_q};
		sts.ptr_bad      = (jump_target >= 14'(len_q)) ||
		                   (jump_target < 14'(dqne_pkg::HEADER_BYTES));
		sts.b_zero       = pkt_rd_q == 8'h00;
		sts.label_bad    = (pkt_rd_q > dqne_pkg::MAX_LABEL) || (label_end > XW'(len_q));
		sts.copy_more    = (rem_q != 6'd0) && (np_q < NAME_LIMIT) && (rp_q < len_q);
		sts.out_done     = out_valid_q && !name_stall;
		sts.out_last     = out_q.last_chunk;
	end

	// packet store
	assign pkt_rd_en   = cmd.rd_cur | cmd.rd_next | cmd.copy_rd;
	assign pkt_rd_addr = cmd.rd_next ? rp1[AW-1:0] : rp_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_wr && (len_q < LW'(BUFFER_BYTES))) begin
			pkt_mem[len_q[AW-1:0]] <= msg_data.data_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_rd_en) begin
			pkt_rd_q <= pkt_mem[pkt_rd_addr];
		end
	end

	// name store: rows of eight characters, byte writes
	assign name_wr_en   = (cmd.label_go && (np_q != '0)) || cmd.copy_wr;
	assign name_wr_data = cmd.copy_wr ? pkt_rd_q : dqne_pkg::DOT_CHAR;

	always_ff @(posedge clk) begin
		if (name_wr_en) begin
			name_mem[np_q[PW-1:3]][{np_q[2:0], 3'b000} +: 8] <= name_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_rd) begin
			name_rd_q <= name_mem[RW'(chunk_q)];
		end
	end

	// walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			rp_q     <= '0;
			steps_q  <= '0;
			jumps_q  <= '0;
			np_q     <= '0;
			rem_q    <= '0;
			chunk_q  <= '0;
			status_q <= dqne_pkg::ST_OK;
		end else begin
			if (cmd.load_wr && (len_q < LW'(BUFFER_BYTES))) begin
				len_q <= len_q + LW'(1);
			end
			if (cmd.msg_clear) begin
				len_q <= '0;
			end
			if (cmd.walk_init) begin
				rp_q    <= LW'(dqne_pkg::HEADER_BYTES);
				steps_q <= '0;
				jumps_q <= '0;
				np_q    <= '0;
				chunk_q <= '0;
			end
			if (cmd.step_inc) begin
				steps_q <= steps_q + SW'(1);
			end
			if (cmd.rp_inc) begin
				rp_q <= rp1[LW-1:0];
			end
			if (cmd.label_go) begin
				rem_q <= pkt_rd_q[5:0];
				if (np_q != '0) begin
					np_q <= np_q + PW'(1);
				end
			end
			if (cmd.take_ptr) begin
				rp_q    <= LW'(jump_target);
				jumps_q <= jumps_q + JW'(1);
			end
			if (cmd.copy_rd) begin
				rp_q  <= rp1[LW-1:0];
				rem_q <= rem_q - 6'd1;
			end
			if (cmd.copy_wr) begin
				np_q <= np_q + PW'(1);
			end
			if (cmd.fin_done) begin
				status_q <= (np_q != '0) ? dqne_pkg::ST_OK : dqne_pkg::ST_EMPTY;
			end
			if (cmd.fin_short) begin
				status_q <= dqne_pkg::ST_SHORT;
			end
			if (cmd.fin_bad) begin
				status_q <= dqne_pkg::ST_BAD;
			end
			if (cmd.chunk_inc) begin
				chunk_q <= chunk_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.label_go || cmd.rd_next) begin
			b_q <= pkt_rd_q;
		end
	end

	// chunk formation
	assign tot9        = 9'(np_q);
	assign left9       = tot9 - {2'b00, chunk_q, 3'b000};
	assign nbytes      = (left9 >= 9'd8) ? 4'd8 : left9[3:0];
	assign nchunks_raw = 6'((tot9 + 9'd7) >> 3);

	always_comb begin
		if (nchunks_raw == 6'd0) begin
			nchunks = 5'd1;
		end else if (nchunks_raw > 6'(dqne_pkg::MAX_RESULTS)) begin
			nchunks = 5'(dqne_pkg::MAX_RESULTS);
		end else begin
			nchunks = nchunks_raw[4:0];
		end
	end

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			chunk_word[8*k +: 8] = (4'(k) < nbytes) ? name_rd_q[8*k +: 8] : 8'h00;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !name_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.name_chunk  <= chunk_word;
			out_q.chunk_bytes <= nbytes;
			out_q.name_length <= 7'(np_q);
			out_q.status      <= status_q;
			out_q.last_chunk  <= ({1'b0, chunk_q} + 5'd1) == nchunks;
		end
	end

	assign name_valid = out_valid_q;
	assign name_data  = out_q;

endmodule

/* rtl/core/dqne_ctrl.sv */
// ----------------------------------------------------------------------------
// dqne_ctrl
// Sequencer: message load, name walk, chunk emission.
// ----------------------------------------------------------------------------
module dqne_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           msg_valid,
	output logic           msg_stall,
	input  dqne_pkg::sts_t sts,
	output dqne_pkg::cmd_t cmd
);

	typedef enum logic [9:0] {
		S_LOAD   = 10'b0000000001,
		S_WSTART = 10'b0000000010,
		S_STEP   = 10'b0000000100,
		S_HEAD   = 10'b0000001000,
		S_PTR    = 10'b0000010000,
		S_CPRD   = 10'b0000100000,
		S_CPWR   = 10'b0001000000,
		S_EMRD   = 10'b0010000000,
		S_EMLD   = 10'b0100000000,
		S_EMWAIT = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	assign msg_stall = (state_q != S_LOAD);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_LOAD: begin
				if (msg_valid) begin
					cmd.load_wr = 1'b1;
					if (sts.eom) begin
						state_d = S_WSTART;
					end
				end
			end
			S_WSTART: begin
				cmd.walk_init = 1'b1;
				if (sts.short_msg) begin
					cmd.fin_short = 1'b1;
					state_d       = S_EMRD;
				end else begin
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				if (sts.loop_done) begin
					cmd.fin_done = 1'b1;
					state_d      = S_EMRD;
				end else begin
					cmd.step_inc = 1'b1;
					if (sts.rp_end) begin
						cmd.fin_done = 1'b1;
						state_d      = S_EMRD;
					end else begin
						cmd.rd_cur = 1'b1;
						state_d    = S_HEAD;
					end
				end
			end
			S_HEAD: begin
				if (sts.is_ptr) begin
					if (sts.ptr_next_end) begin
						cmd.fin_done = 1'b1;
						state_d      = S_EMRD;
					end else begin
						cmd.rd_next = 1'b1;
						state_d     = S_PTR;
					end
				end else begin
					cmd.rp_inc = 1'b1;
					if (sts.b_zero) begin
						cmd.fin_done = 1'b1;
						state_d      = S_EMRD;
					end else if (sts.label_bad) begin
						cmd.fin_bad = 1'b1;
						state_d     = S_EMRD;
					end else begin
						cmd.label_go = 1'b1;
						state_d      = S_CPRD;
					end
				end
			end
			S_PTR: begin
				if (sts.ptr_bad) begin
					cmd.fin_done = 1'b1;
					state_d      = S_EMRD;
				end else begin
					cmd.take_ptr = 1'b1;
					state_d      = S_STEP;
				end
			end
			S_CPRD: begin
				if (sts.copy_more) begin
					cmd.copy_rd = 1'b1;
					state_d     = S_CPWR;
				end else begin
					state_d = S_STEP;
				end
			end
			S_CPWR: begin
				cmd.copy_wr = 1'b1;
				state_d     = S_CPRD;
			end
			S_EMRD: begin
				cmd.emit_rd = 1'b1;
				state_d     = S_EMLD;
			end
			S_EMLD: begin
				cmd.out_load = 1'b1;
				state_d      = S_EMWAIT;
			end
			S_EMWAIT: begin
				if (sts.out_done) begin
					if (sts.out_last) begin
						cmd.msg_clear = 1'b1;
						state_d       = S_LOAD;
					end else begin
						cmd.chunk_inc = 1'b1;
						state_d       = S_EMRD;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/dns_query_name_extractor.sv */
// Sequence: message bytes load one per cycle; after the final byte the walk starts,
//   reads each label or pointer head, then reads and writes each name character,
//   then emits each result chunk (read, load, wait out output stalls), up to 16 chunks.
// Throughput: one message at a time; input is stalled from the final byte until the
//   last chunk transaction completes. The packet store's single read port sets the walk pace.
// Reset: arst_n clears control state only; packet and name stores are not cleared.
// ----------------------------------------------------------------------------
// dns_query_name_extractor
// Buffers a DNS message, walks the question name with compression pointers
// and emits the dotted name in 8-byte chunks with length and status.
// ----------------------------------------------------------------------------
module dns_query_name_extractor #(
	parameter int unsigned BUFFER_BYTES = 512,
	parameter int unsigned NAME_BYTES   = 128,
	parameter int unsigned MAX_STEPS    = 32,
	parameter int unsigned MAX_JUMPS    = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            msg_valid,
	output logic            msg_stall,
	input  dqne_pkg::msg_t  msg_data,
	output logic            name_valid,
	input  logic            name_stall,
	output dqne_pkg::name_t name_data
);

	dqne_pkg::cmd_t cmd;
	dqne_pkg::sts_t sts;

	dqne_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	dqne_datapath #(
		.BUFFER_BYTES (BUFFER_BYTES),
		.NAME_BYTES   (NAME_BYTES),
		.MAX_STEPS    (MAX_STEPS),
		.MAX_JUMPS    (MAX_JUMPS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_data   (msg_data),
		.name_stall (name_stall),
		.name_valid (name_valid),
		.name_data  (name_data),
		.cmd        (cmd),
		.sts        (sts)
	);

`ifndef SYNTHESIS
	// input is only open when no result is pending
	a_load_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		!msg_stall |-> !name_valid)
		else $error("input open while result pending");

	// final byte closes the input
	a_eom_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_valid && !msg_stall && msg_data.end_of_message) |=> msg_stall)
		else $error("input not stalled after final byte");

	// last chunk transaction reopens the input
	a_last_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		(name_valid && !name_stall && name_data.last_chunk) |=> !msg_stall)
		else $error("input not reopened after last chunk");

	a_chunk_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		name_valid |-> (name_data.chunk_bytes <= 4'd8))
		else $error("chunk byte count out of range");
`endif

endmodule

/* tb/tb_dns_query_name_extractor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dns_query_name_extractor
// Streams DNS messages into the extractor byte by byte and checks every name
// chunk it returns against a scoreboard. The scoreboard rebuilds each message,
// walks the question name itself (labels, compression pointers, step, jump
// and length limits) and queues the chunks it expects. Directed messages cover
// the corner cases; random messages are mostly well-formed packets with random
// content, plus truncated, corrupted and noise packets. Both sides idle at
// random, and one long output hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_dns_query_name_extractor;

	localparam int unsigned BUF_BYTES    = 512;
	localparam int unsigned NAME_MAX     = 128;
	localparam int unsigned STEP_LIMIT   = 32;
	localparam int unsigned JUMP_LIMIT   = 5;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 60;

	class name_scoreboard;
		logic [7:0]      pkt_mem [BUF_BYTES];
		int unsigned     pkt_len;
		logic [7:0]      name_mem [NAME_MAX];
		int unsigned     name_chars;
		dqne_pkg::name_t expected_q [$];
		int unsigned     mismatches;
		int unsigned     messages;
		int unsigned     chunks_expected;
		int unsigned     chunks_checked;
		int unsigned     outcome_cnt [4];

		function new();
			pkt_len = 0;
			name_chars = 0;
			mismatches = 0;
			messages = 0;
			chunks_expected = 0;
			chunks_checked = 0;
			foreach (outcome_cnt[i]) outcome_cnt[i] = 0;
		endfunction

		// walks the question name of the stored message, fills name_mem
		function logic [1:0] walk_question();
			int unsigned rp, b, tgt, k, jumps, steps;
			name_chars = 0;
			jumps = 0;
			steps = 0;
			if (pkt_len < dqne_pkg::HEADER_BYTES)
				return dqne_pkg::ST_SHORT;
			rp = dqne_pkg::HEADER_BYTES;
			while (steps < STEP_LIMIT && name_chars < NAME_MAX - 1 && jumps < JUMP_LIMIT) begin
				steps++;
				if (rp >= pkt_len)
					break;
				b = pkt_mem[rp];
				if ((b & dqne_pkg::PTR_MASK) == dqne_pkg::PTR_MASK) begin
					if (rp + 1 >= pkt_len)
						break;
					tgt = ((b & dqne_pkg::OFFSET_MASK) << 8) | pkt_mem[rp + 1];
					if (tgt >= pkt_len || tgt < dqne_pkg::HEADER_BYTES)
						break;
					rp = tgt;
					jumps++;
					continue;
				end
				rp++;
				if (b == 0)
					break;
				if (b > dqne_pkg::MAX_LABEL || rp + b > pkt_len)
					return dqne_pkg::ST_BAD;
				if (name_chars > 0)
					name_mem[name_chars++] = dqne_pkg::DOT_CHAR;
				for (k = 0; k < b && name_chars < NAME_MAX - 1 && rp < pkt_len; k++)
					name_mem[name_chars++] = pkt_mem[rp++];
			end
			return (name_chars > 0) ? dqne_pkg::ST_OK : dqne_pkg::ST_EMPTY;
		endfunction

		// called for every accepted input transaction
		function void note_byte(dqne_pkg::msg_t m);
			logic [1:0]      st;
			int unsigned     nchunks, c, k, n;
			dqne_pkg::name_t r;
			if (pkt_len < BUF_BYTES)
				pkt_mem[pkt_len++] = m.data_byte;
			if (!m.end_of_message)
				return;
			st = walk_question();
			nchunks = (name_chars + 7) / 8;
			if (nchunks == 0)
				nchunks = 1;
			if (nchunks > dqne_pkg::MAX_RESULTS)
				nchunks = dqne_pkg::MAX_RESULTS;
			for (c = 0; c < nchunks; c++) begin
				r = '0;
				n = 0;
				for (k = 0; k < 8 && c * 8 + k < name_chars; k++) begin
					r.name_chunk[8*k +: 8] = name_mem[c * 8 + k];
					n++;
				end
				r.chunk_bytes = n[3:0];
				r.name_length = name_chars[6:0];
				r.status      = st;
				r.last_chunk  = (c + 1 == nchunks);
				expected_q.push_back(r);
			end
			chunks_expected += nchunks;
			outcome_cnt[st]++;
			messages++;
			pkt_len = 0;
		endfunction

		// called for every accepted output transaction
		function void check_chunk(dqne_pkg::name_t got);
			dqne_pkg::name_t exp;
			chunks_checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected chunk=%h bytes=%0d len=%0d st=%0d last=%0d",
						$realtime, got.name_chunk, got.chunk_bytes, got.name_length,
						got.status, got.last_chunk);
				return;
			end
			exp = expected_q.pop_front();
			if (got.name_chunk !== exp.name_chunk || got.chunk_bytes !== exp.chunk_bytes ||
			    got.name_length !== exp.name_length || got.status !== exp.status ||
			    got.last_chunk !== exp.last_chunk) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: mismatch exp chunk=%h bytes=%0d len=%0d st=%0d last=%0d",
						$realtime, exp.name_chunk, exp.chunk_bytes, exp.name_length,
						exp.status, exp.last_chunk);
					$display("%0t:          got chunk=%h bytes=%0d len=%0d st=%0d last=%0d",
						$realtime, got.name_chunk, got.chunk_bytes, got.name_length,
						got.status, got.last_chunk);
				end
			end
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            msg_valid;
	logic            msg_stall;
	dqne_pkg::msg_t  msg_data;
	logic            name_valid;
	logic            name_stall;
	dqne_pkg::name_t name_data;

	name_scoreboard sb;
	logic [7:0]     pkt_q [$];
	int unsigned    bytes_sent;
	int unsigned    stall_run;
	bit             hold_off;
	bit             no_gaps;

	dns_query_name_extractor #(
		.BUFFER_BYTES(BUF_BYTES),
		.NAME_BYTES(NAME_MAX),
		.MAX_STEPS(STEP_LIMIT),
		.MAX_JUMPS(JUMP_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.msg_valid(msg_valid),
		.msg_stall(msg_stall),
		.msg_data(msg_data),
		.name_valid(name_valid),
		.name_stall(name_stall),
		.name_data(name_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int unsigned pick_label_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 8);
		return $urandom_range(9, 63);
	endfunction

	function automatic void put_header();
		pkt_q.delete();
		repeat (dqne_pkg::HEADER_BYTES) pkt_q.push_back(8'($urandom_range(0, 255)));
	endfunction

	// mostly lowercase letters, now and then any byte value
	function automatic void put_label(int unsigned len);
		pkt_q.push_back(8'(len));
		repeat (len)
			pkt_q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(8'h61, 8'h7A)));
	endfunction

	function automatic void put_text(string s);
		pkt_q.push_back(8'(s.len()));
		for (int i = 0; i < s.len(); i++)
			pkt_q.push_back(s[i]);
	endfunction

	function automatic void put_pointer(int unsigned target);
		logic [13:0] t;
		t = target[13:0];
		pkt_q.push_back(dqne_pkg::PTR_MASK | {2'b00, t[13:8]});
		pkt_q.push_back(t[7:0]);
	endfunction

	function automatic void make_random_message();
		int unsigned kind, cut;
		int unsigned starts [$];
		kind = $urandom_range(0, 99);
		if (kind >= 90) begin
			// noise
			pkt_q.delete();
			repeat ($urandom_range(1, 30)) pkt_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		put_header();
		if (kind >= 60 && kind < 75)
			put_pointer(dqne_pkg::HEADER_BYTES + 2);
		starts.push_back(dqne_pkg::HEADER_BYTES);
		repeat ($urandom_range(1, 4)) begin
			starts.push_back(pkt_q.size());
			put_label(pick_label_len());
		end
		case ($urandom_range(0, 9))
			0, 1: put_pointer(starts[$urandom_range(0, starts.size() - 1)]);
			2: ;
			default: pkt_q.push_back(8'h00);
		endcase
		repeat ($urandom_range(0, 6)) pkt_q.push_back(8'($urandom_range(0, 255)));
		if (kind >= 75) begin
			// truncated or corrupted
			if ($urandom_range(0, 1)) begin
				cut = $urandom_range(1, pkt_q.size());
				while (pkt_q.size() > cut) void'(pkt_q.pop_back());
			end else begin
				pkt_q[$urandom_range(dqne_pkg::HEADER_BYTES, pkt_q.size() - 1)] =
					8'($urandom_range(0, 255));
			end
		end
	endfunction

	task automatic drive_byte(logic [7:0] b, logic eom);
		dqne_pkg::msg_t item;
		item.data_byte = b;
		item.end_of_message = eom;
		@(negedge clk);
		msg_valid <= 1'b1;
		msg_data  <= item;
		do @(posedge clk); while (msg_stall);
		sb.note_byte(item);
		bytes_sent++;
	endtask

	task automatic pause_sender(int unsigned n);
		if (n == 0)
			return;
		@(negedge clk);
		msg_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_message();
		for (int i = 0; i < pkt_q.size(); i++) begin
			pause_sender(no_gaps ? 0 : pick_gap());
			drive_byte(pkt_q[i], i == pkt_q.size() - 1);
		end
	endtask

	// result side: check at the rising edge, pick the next stall at the falling edge
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (name_valid && !name_stall)
				sb.check_chunk(name_data);
			@(negedge clk);
			if (hold_off) begin
				name_stall <= 1'b1;
			end else if (stall_run > 0) begin
				name_stall <= 1'b1;
				stall_run--;
			end else if (!no_gaps) begin
				stall_run = pick_gap();
				name_stall <= (stall_run > 0);
				if (stall_run > 0)
					stall_run--;
			end else begin
				name_stall <= 1'b0;
			end
		end
	end

	// one long output hold-off while input keeps coming
	initial begin
		wait (bytes_sent >= 100);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int unsigned start_bytes, start_chunks, rnd_msgs;
		msg_valid  = 1'b0;
		msg_data   = '0;
		name_stall = 1'b0;
		arst_n     = 1'b0;
		hold_off   = 1'b0;
		no_gaps    = 1'b0;
		stall_run  = 0;
		bytes_sent = 0;
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// shorter than the header
		pkt_q.delete();
		pkt_q.push_back(8'h00);
		send_message();
		pkt_q.delete();
		repeat (11) pkt_q.push_back(8'hFF);
		send_message();
		// root name only
		put_header();
		pkt_q.push_back(8'h00);
		send_message();
		put_header();
		put_text("www");
		put_text("example");
		put_text("com");
		pkt_q.push_back(8'h00);
		send_message();
		// reserved label types
		put_header();
		pkt_q.push_back(8'h40);
		pkt_q.push_back(8'h00);
		send_message();
		put_header();
		put_text("ok");
		pkt_q.push_back(8'hBF);
		pkt_q.push_back(8'h00);
		send_message();
		// label longer than the rest of the message
		put_header();
		pkt_q.push_back(8'd5);
		pkt_q.push_back(8'h61);
		pkt_q.push_back(8'h62);
		send_message();
		// pointer back to the start of the name, stops on the jump limit
		put_header();
		put_text("abc");
		put_pointer(dqne_pkg::HEADER_BYTES);
		send_message();
		// broken pointers: cut off, into the header, past the end
		put_header();
		pkt_q.push_back(dqne_pkg::PTR_MASK);
		send_message();
		put_header();
		put_pointer(5);
		send_message();
		put_header();
		put_pointer(14'h3FFF);
		send_message();
		// forward pointer to a proper name
		put_header();
		put_pointer(dqne_pkg::HEADER_BYTES + 2);
		put_text("fwd");
		put_text("test");
		pkt_q.push_back(8'h00);
		send_message();
		// step limit
		put_header();
		repeat (33) put_text("x");
		pkt_q.push_back(8'h00);
		send_message();
		// full name, sixteen chunks
		put_header();
		repeat (3) put_label(63);
		pkt_q.push_back(8'h00);
		send_message();
		put_header();
		put_label(63);
		put_pointer(dqne_pkg::HEADER_BYTES);
		send_message();
		// overflow: pointer to a label that crosses the end of the buffer
		put_header();
		put_pointer(500);
		while (pkt_q.size() < 500) pkt_q.push_back(8'($urandom_range(0, 255)));
		put_label(20);
		while (pkt_q.size() < 530) pkt_q.push_back(8'($urandom_range(0, 255)));
		send_message();

		start_bytes  = bytes_sent;
		start_chunks = sb.chunks_expected;
		rnd_msgs     = 0;
		while ((bytes_sent - start_bytes < 300 || sb.chunks_expected - start_chunks < 48)
		       && rnd_msgs < 80) begin
			no_gaps = ($urandom_range(0, 5) == 0);
			make_random_message();
			send_message();
			rnd_msgs++;
		end
		no_gaps = 1'b0;
		pause_sender(1);

		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d messages (%0d bytes, %0d random) and %0d name chunks.",
			sb.messages, bytes_sent, rnd_msgs, sb.chunks_checked);
		$display("Outcomes: %0d ok, %0d short, %0d bad label, %0d empty name; %0d mismatches.",
			sb.outcome_cnt[dqne_pkg::ST_OK], sb.outcome_cnt[dqne_pkg::ST_SHORT],
			sb.outcome_cnt[dqne_pkg::ST_BAD], sb.outcome_cnt[dqne_pkg::ST_EMPTY],
			sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
